@@ rtl/core/ptu_pkg.sv @@
package ptu_pkg;

    // default table size and register reset values
    localparam int DEF_MAX_NODES = 64;
    localparam logic [6:0]  RST_NUM_NODES = 7'd64;
    localparam logic [16:0] RST_EVAP_RATE = 17'd6554;
    localparam logic [16:0] RST_LOCAL_RATE = 17'd6554;
    localparam logic [31:0] RST_INIT_LEVEL = 32'h0001_0000;

    // fixed point helpers
    localparam logic [16:0] ONE_Q16 = 17'h1_0000;
    localparam logic [48:0] HALF_Q16 = 49'd32768;
    localparam logic [31:0] LEVEL_MAX = 32'hFFFF_FFFF;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_NUM_NODES  = 2'd0,
        REG_EVAP_RATE  = 2'd1,
        REG_LOCAL_RATE = 2'd2,
        REG_INIT_LEVEL = 2'd3
    } t_reg_idx;

    // command codes
    typedef enum logic [2:0] {
        CMD_LOCAL  = 3'd0,
        CMD_LOAD   = 3'd1,
        CMD_GLOBAL = 3'd2,
        CMD_READ   = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_LU_RD,
        S_LU_M1,
        S_LU_M2,
        S_LU_WR,
        S_LOAD,
        S_RD_RD,
        S_RD_WAIT,
        S_GU_DIV,
        S_GU_RDI,
        S_GU_RD,
        S_GU_MUL,
        S_GU_WR,
        S_GU_END,
        S_DONE
    } t_state;

endpackage

@@ rtl/core/pheromone_table_update.sv @@
// Pheromone table update for an ant colony system.
// Input beats on the s_axis group carry one command each; every command gives
// exactly one result beat on the m_axis group. Configuration is written through
// i_cfg_we / i_cfg_addr / i_cfg_wdata while the block is idle, a rule on the user
// that the block itself does not enforce. The block works on one command at a time;
// s_axis tready is low while busy. One shared multiply-add, one table read port
// and one table write port serve the commands. A global update first runs a
// serial divide for the deposit, then reads, scales and writes each pair.
// The table is stored once per unordered pair, so symmetric writes take one write.
// After reset a clearing pass zeroes all 2**(2*clog2(MAX_NODES)) table entries
//   (4096 at 64 nodes), one entry a cycle, with no input taken meanwhile.
// A result sits in an output register; when the receiver stalls it is held
// and the next command waits in its final step until the register frees.
module pheromone_table_update
    import ptu_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // cmd[2:0], node_a[8:3], node_b[14:9], best_len[46:15], zero[47]
    input  logic [47:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // level[31:0], status[33:32], zero[39:34]
    output logic [39:0] o_m_axis_tdata
);

    localparam int NW   = $clog2(MAX_NODES);
    localparam int CNTW = NW + 1;
    localparam int AW   = 2 * NW;

    t_state r_state, n_state;

    logic [6:0]  r_num_nodes;
    logic [16:0] r_evap;
    logic [16:0] r_lrate;
    logic [31:0] r_init;

    logic [31:0] tbl_mem [2**AW];
    logic [31:0] r_tbl_q;
    logic [AW-1:0] tbl_ra, tbl_wa;
    logic          tbl_we;
    logic [31:0]   tbl_wd;

    logic [NW-1:0] pos_mem [2**NW];
    logic [NW-1:0] r_pos_q;
    logic [NW-1:0] pos_ra;
    logic [MAX_NODES-1:0] r_vld;
    logic [CNTW-1:0] r_tcnt;

    logic [AW-1:0] r_cnt, n_cnt;
    logic          r_clr_cmd, n_clr_cmd;
    logic [NW-1:0] r_a;
    logic [NW-1:0] r_lo, r_hi, r_i, r_j, n_i, n_j;
    logic [31:0]   r_len;
    logic [NW-1:0] r_pos_i, r_pos_j;
    logic          r_vld_i, r_vld_j;
    logic [31:0]   r_dep;
    logic [48:0]   r_acc;
    logic [31:0]   r_res_level, n_res_level;
    logic [1:0]    r_res_status, n_res_status;
    logic          r_oval;
    logic [33:0]   r_odata;

    logic [CNTW-1:0] neff;
    logic [16:0] e_c, r_c;
    logic [16:0] mac_a;
    logic [31:0] mac_b;
    logic [48:0] mac_c, mac_y;
    logic        div_start, div_done;
    logic [31:0] div_q;
    logic        accept, out_free;
    logic [2:0]  in_cmd;
    logic [5:0]  in_a, in_b;
    logic [NW-1:0] ia, ib;
    logic        a_ok, b_ok;
    logic [NW-1:0] dpos;
    logic        adj;
    logic [32:0] gsum;
    logic        j_last, i_last;
    logic        tour_clear, tour_load;

    // active node count and clamped rates
    always_comb begin
        if (32'(r_num_nodes) > 32'(MAX_NODES)) neff = CNTW'(MAX_NODES);
        else neff = CNTW'(r_num_nodes);
    end
    assign e_c = (r_evap > ONE_Q16) ? ONE_Q16 : r_evap;
    assign r_c = (r_lrate > ONE_Q16) ? ONE_Q16 : r_lrate;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_nodes <= RST_NUM_NODES;
            r_evap      <= RST_EVAP_RATE;
            r_lrate     <= RST_LOCAL_RATE;
            r_init      <= RST_INIT_LEVEL;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_NUM_NODES:  r_num_nodes <= i_cfg_wdata[6:0];
                REG_EVAP_RATE:  r_evap      <= i_cfg_wdata[16:0];
                REG_LOCAL_RATE: r_lrate     <= i_cfg_wdata[16:0];
                REG_INIT_LEVEL: r_init      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input fields and range checks
    assign in_cmd = i_s_axis_tdata[2:0];
    assign in_a   = i_s_axis_tdata[8:3];
    assign in_b   = i_s_axis_tdata[14:9];
    assign ia     = NW'(in_a);
    assign ib     = NW'(in_b);
    assign a_ok   = 32'(in_a) < 32'(neff);
    assign b_ok   = 32'(in_b) < 32'(neff);
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_oval || i_m_axis_tready;

    // shared multiply-add unit
    ptu_mac u_mac (
        .i_a (mac_a),
        .i_b (mac_b),
        .i_c (mac_c),
        .o_y (mac_y)
    );

    // serial divider for the deposit
    ptu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({e_c, 16'd0}),
        .i_divisor  (r_len),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // tour adjacency of the current pair
    assign dpos = (r_pos_i > r_pos_j) ? r_pos_i - r_pos_j : r_pos_j - r_pos_i;
    assign adj  = r_vld_i && r_vld_j &&
                  (32'(dpos) == 32'd1 || 32'(dpos) == 32'(neff) - 32'd1);
    assign gsum = 33'(r_acc[47:16]) + (adj ? 33'(r_dep) : 33'd0);
    assign j_last = 32'(r_j) == 32'(neff) - 32'd1;
    assign i_last = 32'(r_i) + 32'd2 == 32'(neff);

    // sequencer: next state, memory ports, unit operands
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_clr_cmd    = r_clr_cmd;
        n_i          = r_i;
        n_j          = r_j;
        n_res_level  = r_res_level;
        n_res_status = r_res_status;
        tbl_ra       = {r_lo, r_hi};
        tbl_wa       = {r_lo, r_hi};
        tbl_we       = 1'b0;
        tbl_wd       = '0;
        pos_ra       = r_j;
        mac_a        = ONE_Q16 - e_c;
        mac_b        = r_tbl_q;
        mac_c        = HALF_Q16;
        div_start    = 1'b0;
        tour_clear   = 1'b0;
        tour_load    = 1'b0;
        case (r_state)
            S_CLR: begin
                tbl_we = 1'b1;
                tbl_wa = r_cnt;
                n_cnt  = r_cnt + AW'(1);
                if (&r_cnt) n_state = r_clr_cmd ? S_DONE : S_IDLE;
            end
            S_IDLE: begin
                n_res_level  = '0;
                n_res_status = ST_OK;
                n_clr_cmd    = 1'b0;
                if (accept) begin
                    case (in_cmd)
                        CMD_LOCAL, CMD_READ: begin
                            if (!a_ok || !b_ok) begin
                                n_res_status = ST_RANGE;
                                n_state      = S_DONE;
                            end else begin
                                n_state = (in_cmd == CMD_LOCAL) ? S_LU_RD : S_RD_RD;
                            end
                        end
                        CMD_LOAD: begin
                            if (!a_ok) begin
                                n_res_status = ST_RANGE;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_LOAD;
                            end
                        end
                        CMD_GLOBAL: n_state = S_GU_DIV;
                        CMD_CLEAR: begin
                            n_clr_cmd = 1'b1;
                            n_cnt     = '0;
                            n_state   = S_CLR;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_LU_RD: n_state = S_LU_M1;
            S_LU_M1: begin
                mac_a   = ONE_Q16 - r_c;
                n_state = S_LU_M2;
            end
            S_LU_M2: begin
                mac_a   = r_c;
                mac_b   = r_init;
                mac_c   = r_acc;
                n_state = S_LU_WR;
            end
            S_LU_WR: begin
                tbl_we      = 1'b1;
                tbl_wd      = r_acc[47:16];
                n_res_level = r_acc[47:16];
                n_state     = S_DONE;
            end
            S_LOAD: begin
                if (32'(r_tcnt) >= 32'(neff)) n_res_status = ST_FULL;
                else tour_load = 1'b1;
                n_state = S_DONE;
            end
            S_RD_RD: n_state = S_RD_WAIT;
            S_RD_WAIT: begin
                n_res_level = r_tbl_q;
                n_state     = S_DONE;
            end
            S_GU_DIV: begin
                n_i = '0;
                n_j = NW'(1);
                if (32'(neff) < 32'd2) n_state = S_GU_END;
                else if (r_len == '0 || e_c == '0) n_state = S_GU_RDI;
                else if (div_done) n_state = S_GU_RDI;
                else if (r_cnt == '0) begin
                    div_start = 1'b1;
                    n_cnt     = AW'(1);
                end
            end
            S_GU_RDI: begin
                pos_ra  = r_i;
                n_state = S_GU_RD;
            end
            S_GU_RD: begin
                tbl_ra  = {r_i, r_j};
                pos_ra  = r_j;
                n_state = S_GU_MUL;
            end
            S_GU_MUL: n_state = S_GU_WR;
            S_GU_WR: begin
                tbl_we = 1'b1;
                tbl_wa = {r_i, r_j};
                tbl_wd = gsum[32] ? LEVEL_MAX : gsum[31:0];
                // row position again for the next pair of this row
                pos_ra = r_i;
                if (!j_last) begin
                    n_j     = r_j + NW'(1);
                    n_state = S_GU_RD;
                end else if (i_last) begin
                    n_state = S_GU_END;
                end else begin
                    n_i     = r_i + NW'(1);
                    n_j     = r_i + NW'(2);
                    n_state = S_GU_RDI;
                end
            end
            S_GU_END: begin
                tour_clear = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_cnt     <= '0;
            r_clr_cmd <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= (r_state == S_IDLE && n_state == S_GU_DIV) ? '0 : n_cnt;
            r_clr_cmd <= n_clr_cmd;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_i          <= n_i;
        r_j          <= n_j;
        r_res_level  <= n_res_level;
        r_res_status <= n_res_status;
        if (accept) begin
            r_a   <= ia;
            r_lo  <= (ia < ib) ? ia : ib;
            r_hi  <= (ia < ib) ? ib : ia;
            r_len <= i_s_axis_tdata[46:15];
        end
        if (r_state == S_LU_M1 || r_state == S_LU_M2 || r_state == S_GU_MUL) begin
            r_acc <= mac_y;
        end
        if (r_state == S_GU_DIV) begin
            if (e_c == '0) r_dep <= '0;
            else if (r_len == '0) r_dep <= LEVEL_MAX;
            else r_dep <= div_q;
        end
        if (r_state == S_GU_RD) begin
            r_pos_i <= r_pos_q;
            r_vld_i <= r_vld[r_i];
        end
        if (r_state == S_GU_MUL) begin
            r_pos_j <= r_pos_q;
            r_vld_j <= r_vld[r_j];
        end
    end

    // pheromone table memory, one entry per unordered pair
    always_ff @(posedge i_clk) begin
        if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
        r_tbl_q <= tbl_mem[tbl_ra];
    end

    // tour position memory, a repeated node keeps its first position
    always_ff @(posedge i_clk) begin
        if (tour_load && !r_vld[r_a]) begin
            pos_mem[r_a] <= NW'(r_tcnt);
        end
        r_pos_q <= pos_mem[pos_ra];
    end

    // tour valid bits and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_tcnt <= '0;
        end else if (tour_clear) begin
            r_vld  <= '0;
            r_tcnt <= '0;
        end else if (tour_load) begin
            r_vld[r_a] <= 1'b1;
            r_tcnt <= r_tcnt + CNTW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_oval  <= 1'b1;
            r_odata <= {r_res_status, r_res_level};
        end else if (i_m_axis_tready) begin
            r_oval <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_oval;
    assign o_m_axis_tdata  = {6'd0, r_odata};

    // a result beat never carries a level beside a nonzero status
    a_status_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[33:32] != ST_OK |-> o_m_axis_tdata[31:0] == '0)
        else $error("level not zero on error status");

    // one command at a time: no accept right after an accept
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_axis_tready)
        else $error("input accepted while busy");

    // a loaded tour never grows past the table
    a_tour_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tour_load |-> 32'(r_tcnt) < 32'(MAX_NODES))
        else $error("tour count overflow");

endmodule

@@ rtl/core/ptu_mac.sv @@
module ptu_mac
    import ptu_pkg::*;
(
    input  logic [16:0] i_a,
    input  logic [31:0] i_b,
    input  logic [48:0] i_c,
    output logic [48:0] o_y
);

    // shared multiply-add, rate times level plus accumulator
    assign o_y = 49'(49'(i_a) * 49'(i_b)) + i_c;

endmodule

@@ rtl/core/ptu_div.sv @@
module ptu_div
    import ptu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);

    logic [32:0] r_rem;
    logic [32:0] r_quo;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] rem_sh;
    logic        take;

    // one quotient bit a cycle, restoring
    assign rem_sh = {r_rem, r_quo[32]};
    assign take   = rem_sh >= 34'(i_divisor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
                r_rem  <= '0;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem  <= take ? 33'(rem_sh - 34'(i_divisor)) : 33'(rem_sh);
                r_quo  <= {r_quo[31:0], take};
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient saturates to the level range
    assign o_done = r_done;
    assign o_quot = r_quo[32] ? LEVEL_MAX : r_quo[31:0];

endmodule

@@ bench/tb_pheromone_checker.sv @@
module tb_pheromone_checker
    import ptu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // cmd[2:0], node_a[8:3], node_b[14:9], best_len[46:15], zero[47]
    input  logic [47:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // level[31:0], status[33:32], zero[39:34]
    input  logic [39:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_global_count,
    output int          o_deposit_count
);

    localparam int NODES = DEF_MAX_NODES;

    typedef struct packed {
        logic [31:0] level;
        logic [1:0]  status;
    } t_result;

    // predictor state
    logic [31:0] level_q  [NODES][NODES];
    logic        on_tour  [NODES];
    logic [6:0]  tour_pos [NODES];
    logic [6:0]  tour_len;
    logic [6:0]  cfg_nodes;
    logic [16:0] cfg_evap;
    logic [16:0] cfg_local;
    logic [31:0] cfg_init;

    t_result expected_q[$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    function automatic logic [16:0] clamp_q16(input logic [16:0] r);
        return (r > ONE_Q16) ? ONE_Q16 : r;
    endfunction

    // apply one command to the predictor and return its result
    function automatic t_result predict_pheromone(input logic [47:0] beat);
        logic [2:0]  cmd;
        logic [5:0]  a;
        logic [5:0]  b;
        logic [31:0] plen;
        logic [6:0]  n;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] dep;
        logic [63:0] v;
        logic [6:0]  d;
        t_result     res;
        cmd  = beat[2:0];
        a    = beat[8:3];
        b    = beat[14:9];
        plen = beat[46:15];
        n    = (cfg_nodes > NODES) ? 7'(NODES) : cfg_nodes;
        res  = '0;
        case (cmd)
            CMD_LOCAL: begin
                if (a >= n || b >= n) begin
                    res.status = ST_RANGE;
                end else begin
                    r = 64'(clamp_q16(cfg_local));
                    v = ((64'(ONE_Q16) - r) * 64'(level_q[a][b]) + r * 64'(cfg_init)
                         + 64'd32768) >> 16;
                    res.level = v[31:0];
                    level_q[a][b] = v[31:0];
                    level_q[b][a] = v[31:0];
                end
            end
            CMD_LOAD: begin
                if (a >= n) begin
                    res.status = ST_RANGE;
                end else if (tour_len >= n) begin
                    res.status = ST_FULL;
                end else begin
                    if (!on_tour[a]) begin
                        on_tour[a]  = 1'b1;
                        tour_pos[a] = tour_len;
                    end
                    tour_len++;
                end
            end
            CMD_GLOBAL: begin
                o_global_count++;
                e = 64'(clamp_q16(cfg_evap));
                if (plen == 0) dep = (e == 0) ? 64'd0 : 64'(LEVEL_MAX);
                else begin
                    dep = (e << 16) / 64'(plen);
                    if (dep > 64'(LEVEL_MAX)) dep = 64'(LEVEL_MAX);
                end
                for (int i = 0; i < n; i++) begin
                    for (int j = i + 1; j < n; j++) begin
                        v = ((64'(ONE_Q16) - e) * 64'(level_q[i][j]) + 64'd32768) >> 16;
                        if (on_tour[i] && on_tour[j]) begin
                            d = (tour_pos[i] > tour_pos[j]) ? tour_pos[i] - tour_pos[j]
                                                            : tour_pos[j] - tour_pos[i];
                            if (d == 1 || d == n - 1) begin
                                o_deposit_count++;
                                v = v + dep;
                                if (v > 64'(LEVEL_MAX)) v = 64'(LEVEL_MAX);
                            end
                        end
                        level_q[i][j] = v[31:0];
                        level_q[j][i] = v[31:0];
                    end
                end
                for (int i = 0; i < NODES; i++) on_tour[i] = 1'b0;
                tour_len = '0;
            end
            CMD_READ: begin
                if (a >= n || b >= n) res.status = ST_RANGE;
                else res.level = level_q[a][b];
            end
            CMD_CLEAR: begin
                for (int i = 0; i < NODES; i++)
                    for (int j = 0; j < NODES; j++) level_q[i][j] = '0;
            end
            default: ;
        endcase
        return res;
    endfunction

    // watch config, input and output beats
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) begin
                for (int j = 0; j < NODES; j++) level_q[i][j] = '0;
                on_tour[i]  = 1'b0;
                tour_pos[i] = '0;
            end
            tour_len  = '0;
            cfg_nodes = RST_NUM_NODES;
            cfg_evap  = RST_EVAP_RATE;
            cfg_local = RST_LOCAL_RATE;
            cfg_init  = RST_INIT_LEVEL;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_addr))
                    REG_NUM_NODES:  cfg_nodes = i_cfg_wdata[6:0];
                    REG_EVAP_RATE:  cfg_evap  = i_cfg_wdata[16:0];
                    REG_LOCAL_RATE: cfg_local = i_cfg_wdata[16:0];
                    REG_INIT_LEVEL: cfg_init  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                o_result_count++;
                if (expected_q.size() == 0) begin
                    report("unexpected result beat", i_m_tdata[31:0], '0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_m_tdata[31:0] !== want.level)
                        report("level", i_m_tdata[31:0], want.level);
                    if (i_m_tdata[33:32] !== want.status)
                        report("status", 32'(i_m_tdata[33:32]), 32'(want.status));
                    if (i_m_tdata[39:34] !== '0)
                        report("pad bits", 32'(i_m_tdata[39:34]), '0);
                end
            end
            if (i_s_tvalid && i_s_tready) expected_q.push_back(predict_pheromone(i_s_tdata));
        end
        o_pending = expected_q.size();
    end

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_result_count  = 0;
        o_global_count  = 0;
        o_deposit_count = 0;
    end

endmodule

@@ bench/tb_pheromone_table_update.sv @@
module tb_pheromone_table_update;
    import ptu_pkg::*;

    localparam int  RANDOM_ITEMS = 1500;
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    int          fail_count;
    int          pending;
    int          result_count;
    int          global_count;
    int          deposit_count;
    longint      cycle_count;
    bit          no_idle;
    logic [6:0]  cur_nodes;

    pheromone_table_update i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    tb_pheromone_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_global_count (global_count),
        .o_deposit_count(deposit_count)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(negedge i_clk) begin
        int gap;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
            m_tready <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        m_tready <= 1'b1;
    end

    // send one command beat, sometimes after a random gap; valid stays up after the beat
    task automatic send_cmd(input t_cmd cmd, input logic [5:0] a, input logic [5:0] b,
                            input logic [31:0] plen);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, plen, b, a, cmd};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_raw(input logic [2:0] cmd, input logic [5:0] a, input logic [5:0] b,
                            input logic [31:0] plen);
        send_cmd(t_cmd'(cmd), a, b, plen);
    endtask

    // stop sending, wait until all results are in, then let some idle cycles pass
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (6500) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == REG_NUM_NODES) cur_nodes = value[6:0];
        @(negedge i_clk);
    endtask

    function automatic logic [5:0] pick_node(input logic [6:0] n);
        int lim;
        lim = (n > 64) ? 64 : n;
        if ($urandom_range(0, 15) == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [31:0] pick_length;
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(1, 16));
            default: return $urandom();
        endcase
    endfunction

    // one random tour: load nodes, then a global update
    task automatic random_tour;
        int len;
        len = $urandom_range(1, (cur_nodes > 64 ? 64 : cur_nodes) + 1);
        for (int k = 0; k < len; k++)
            send_cmd(CMD_LOAD, pick_node(cur_nodes), 6'($urandom()), $urandom());
        send_cmd(CMD_GLOBAL, 6'($urandom()), 6'($urandom()), pick_length());
    endtask

    // random mix: mostly local updates and reads, some tours, loads, clears and unknown codes
    task automatic random_phase(input int count);
        int k;
        k = 0;
        while (k < count) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    random_tour();
                    k += 4;
                end
                2: begin
                    send_raw(3'($urandom_range(5, 7)), 6'($urandom()), 6'($urandom()),
                             $urandom());
                    k++;
                end
                3: begin
                    if ($urandom_range(0, 9) == 0)
                        send_cmd(CMD_CLEAR, 6'($urandom()), 6'($urandom()), $urandom());
                    else send_cmd(CMD_LOAD, pick_node(cur_nodes), 6'($urandom()), $urandom());
                    k++;
                end
                4, 5, 6, 7, 8, 9: begin
                    send_cmd(CMD_READ, pick_node(cur_nodes), pick_node(cur_nodes), $urandom());
                    k++;
                end
                default: begin
                    send_cmd(CMD_LOCAL, pick_node(cur_nodes), pick_node(cur_nodes), $urandom());
                    k++;
                end
            endcase
        end
    endtask

    initial begin
        cycle_count = 0;
        no_idle     = 1'b0;
        cur_nodes   = RST_NUM_NODES;
        i_rst_n     = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = REG_NUM_NODES;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default setup, extremes and special cases
        send_cmd(CMD_LOCAL, 6'd0, 6'd63, 32'd0);
        send_cmd(CMD_LOCAL, 6'd63, 6'd63, 32'd0);
        send_cmd(CMD_READ, 6'd63, 6'd0, 32'd0);
        send_cmd(CMD_READ, 6'd63, 6'd63, 32'hFFFF_FFFF);
        send_raw(3'd5, 6'd1, 6'd2, 32'd0);
        send_raw(3'd7, 6'd63, 6'd63, 32'hFFFF_FFFF);
        for (int k = 0; k < 4; k++) send_cmd(CMD_LOAD, 6'(k * 21), 6'd0, 32'd0);
        send_cmd(CMD_LOAD, 6'd21, 6'd0, 32'd0);
        send_cmd(CMD_GLOBAL, 6'd0, 6'd0, 32'd0);
        send_cmd(CMD_READ, 6'd0, 6'd21, 32'd0);
        drain();

        // small table: range errors, full tour, saturated deposit
        write_reg(REG_NUM_NODES, 32'd2);
        write_reg(REG_EVAP_RATE, 32'h1FFFF);
        write_reg(REG_LOCAL_RATE, 32'h1_0000);
        write_reg(REG_INIT_LEVEL, 32'hFFFF_FFFF);
        send_cmd(CMD_LOCAL, 6'd2, 6'd0, 32'd0);
        send_cmd(CMD_LOCAL, 6'd0, 6'd1, 32'd0);
        send_cmd(CMD_READ, 6'd1, 6'd2, 32'd0);
        send_cmd(CMD_LOAD, 6'd2, 6'd0, 32'd0);
        send_cmd(CMD_LOAD, 6'd1, 6'd0, 32'd0);
        send_cmd(CMD_LOAD, 6'd0, 6'd0, 32'd0);
        send_cmd(CMD_LOAD, 6'd0, 6'd0, 32'd0);
        send_cmd(CMD_GLOBAL, 6'd0, 6'd0, 32'd1);
        send_cmd(CMD_READ, 6'd1, 6'd0, 32'd0);
        send_cmd(CMD_CLEAR, 6'd0, 6'd0, 32'd0);
        send_cmd(CMD_READ, 6'd1, 6'd0, 32'd0);
        drain();

        // count below two, and zero rates
        write_reg(REG_NUM_NODES, 32'd1);
        write_reg(REG_EVAP_RATE, 32'd0);
        write_reg(REG_LOCAL_RATE, 32'd0);
        write_reg(REG_INIT_LEVEL, 32'd0);
        send_cmd(CMD_LOAD, 6'd0, 6'd0, 32'd0);
        send_cmd(CMD_GLOBAL, 6'd0, 6'd0, 32'd0);
        send_cmd(CMD_LOCAL, 6'd0, 6'd0, 32'd0);
        drain();

        // random phases over several settings
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: write_reg(REG_NUM_NODES, 32'd5);
                1: write_reg(REG_NUM_NODES, 32'd127);
                default: write_reg(REG_NUM_NODES, 32'($urandom_range(2, 12)));
            endcase
            write_reg(REG_EVAP_RATE, (p == 2) ? 32'h1_0000 : 32'($urandom_range(0, 65536)));
            write_reg(REG_LOCAL_RATE, (p == 3) ? 32'h1FFFF : 32'($urandom_range(0, 65536)));
            write_reg(REG_INIT_LEVEL, (p == 4) ? 32'hFFFF_FFFF : $urandom());
            no_idle = (p == 5);
            random_phase((p == 1) ? 100 : RANDOM_ITEMS / 5);
            // wait for the block to catch up before moving on
            drain();
        end

        $display("covered %0d results, %0d global updates with %0d tour deposits",
                 result_count, global_count, deposit_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ pheromone_table_update.f @@
rtl/core/ptu_pkg.sv
rtl/core/ptu_mac.sv
rtl/core/ptu_div.sv
rtl/core/pheromone_table_update.sv
bench/tb_pheromone_checker.sv
bench/tb_pheromone_table_update.sv
